// ===== rtl/signed_int_to_radix_text_top_assert.svh =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top_assert.svh
// assertion macros shared by the radix text converter modules
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_RADIX_TEXT_TOP_ASSERT_SVH
`define SIGNED_INT_TO_RADIX_TEXT_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// plain property, checked on every edge outside reset
`define SIRT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("sirt assertion failed");
// same-cycle implication
`define SIRT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sirt implication failed");
`else
`define SIRT_ASSERT(lbl, clk, rstn, prop)
`define SIRT_IMPLY(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== rtl/sirt_pkg.sv =====
// ----------------------------------------------------------------------------
// sirt_pkg
// shared constants, types and the digit character lookup of the radix text
// converter
// ----------------------------------------------------------------------------
package sirt_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int MAX_CHARS    = 33;
    localparam int RADIX_MIN    = 2;
    localparam int RADIX_MAX    = 36;

    localparam int RADIX_W   = 6;
    localparam int CHAR_W    = 8;
    localparam int DIGIT_W   = $clog2(RADIX_MAX);
    localparam int BIT_CNT_W = $clog2(NUMBER_WIDTH);
    localparam int IDX_W     = $clog2(MAX_CHARS);
    localparam int CNT_W     = $clog2(MAX_CHARS + 1);

    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0] ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0] ALPHA_CHAR = 8'h41;
    localparam logic [CHAR_W-1:0] NUL_CHAR   = 8'h00;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMPTY,
        ST_DIV,
        ST_STORE,
        ST_SIGN,
        ST_READ,
        ST_PUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic div_step;
        logic store_digit;
        logic rd_issue;
        logic load_sign;
        logic load_digit;
        logic load_empty;
        logic idx_dec;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic div_last;
        logic quot_zero;
        logic negative;
        logic idx_zero;
        logic out_free;
    } sts_t;

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] dx;
        dx = CHAR_W'(d);
        if (d < DIGIT_W'(10))
            return ZERO_CHAR + dx;
        else if (d < DIGIT_W'(RADIX_MAX))
            return ALPHA_CHAR + dx - CHAR_W'(10);
        else
            return NUL_CHAR;
    endfunction

endpackage

// ===== rtl/sirt_ctrl.sv =====
// ----------------------------------------------------------------------------
// sirt_ctrl
// sequencer: accepts an item, runs the bit-serial divider once per digit,
// then walks the digit store from the top and hands out one beat per character,
// or a single empty beat when the base is out of range
`include "signed_int_to_radix_text_top_assert.svh"

module sirt_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic [sirt_pkg::RADIX_W-1:0]       radix,
    input  sirt_pkg::sts_t                     sts,
    output sirt_pkg::cmd_t                     cmd,
    output logic                               in_stall
);

    sirt_pkg::state_t state_reg;
    sirt_pkg::state_t state_next;
    logic             radix_ok;

    assign radix_ok = (radix >= sirt_pkg::RADIX_W'(sirt_pkg::RADIX_MIN))
                   && (radix <= sirt_pkg::RADIX_W'(sirt_pkg::RADIX_MAX));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sirt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            sirt_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = radix_ok ? sirt_pkg::ST_DIV : sirt_pkg::ST_EMPTY;
                end
            end
            sirt_pkg::ST_EMPTY:
            begin
                if (sts.out_free)
                begin
                    cmd.load_empty = 1'b1;
                    state_next     = sirt_pkg::ST_IDLE;
                end
            end
            sirt_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = sirt_pkg::ST_STORE;
                end
            end
            sirt_pkg::ST_STORE:
            begin
                cmd.store_digit = 1'b1;
                if (!sts.quot_zero)
                    state_next = sirt_pkg::ST_DIV;
                else if (sts.negative)
                    state_next = sirt_pkg::ST_SIGN;
                else
                    state_next = sirt_pkg::ST_READ;
            end
            sirt_pkg::ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    cmd.load_sign = 1'b1;
                    state_next    = sirt_pkg::ST_READ;
                end
            end
            sirt_pkg::ST_READ:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = sirt_pkg::ST_PUT;
            end
            sirt_pkg::ST_PUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_digit = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = sirt_pkg::ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_dec = 1'b1;
                        state_next  = sirt_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = sirt_pkg::ST_IDLE;
            end
        endcase
    end

    // at most one source fills the output register in a cycle
    `SIRT_ASSERT(a_one_load, clk, rst_n, $onehot0({cmd.load_sign, cmd.load_digit, cmd.load_empty}))
    // the output register is only filled when it has room
    `SIRT_IMPLY(a_load_free, clk, rst_n, cmd.load_sign || cmd.load_digit || cmd.load_empty, sts.out_free)
    // a digit is stored only right after the final divider step
    `SIRT_IMPLY(a_store_after_div, clk, rst_n, cmd.store_digit, $past(cmd.div_step) && $past(sts.div_last))

endmodule

// ===== rtl/sirt_dpath.sv =====
// ----------------------------------------------------------------------------
// sirt_dpath
// magnitude register, restoring divider (one quotient bit per cycle),
// digit store and output register
// ----------------------------------------------------------------------------
`include "signed_int_to_radix_text_top_assert.svh"

module sirt_dpath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  sirt_pkg::cmd_t                          cmd,
    output sirt_pkg::sts_t                          sts,
    input  logic signed [sirt_pkg::NUMBER_WIDTH-1:0] number,
    input  logic [sirt_pkg::RADIX_W-1:0]            radix,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]             character,
    output logic                                    is_empty,
    output logic                                    last
);

    localparam int NW = sirt_pkg::NUMBER_WIDTH;
    localparam int DW = sirt_pkg::DIGIT_W;

    logic [NW-1:0]                    q_reg,     q_next;
    logic [DW-1:0]                    rem_reg,   rem_next;
    logic [sirt_pkg::RADIX_W-1:0]     radix_reg, radix_next;
    logic                             neg_reg,   neg_next;
    logic [sirt_pkg::BIT_CNT_W-1:0]   bit_reg,   bit_next;
    logic [sirt_pkg::CNT_W-1:0]       cnt_reg,   cnt_next;
    logic [sirt_pkg::IDX_W-1:0]       idx_reg,   idx_next;
    logic                             out_valid_reg, out_valid_next;

    logic [DW-1:0]                    digit_mem [sirt_pkg::MAX_CHARS];
    logic [DW-1:0]                    rd_data_reg;
    logic [sirt_pkg::CHAR_W-1:0]      char_reg;
    logic                             empty_reg;
    logic                             last_reg;

    logic [NW-1:0]                    num_u;
    logic [NW-1:0]                    magnitude;
    logic [DW:0]                      rem_shift;
    logic [DW:0]                      rem_sub;
    logic                             rem_ge;

    assign num_u     = number;
    assign magnitude = num_u[NW-1] ? (~num_u + 1'b1) : num_u;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, q_reg[NW-1]};
    assign rem_sub   = rem_shift - (DW+1)'(radix_reg);
    assign rem_ge    = rem_shift >= (DW+1)'(radix_reg);

    always_comb
    begin
        q_next         = q_reg;
        rem_next       = rem_reg;
        radix_next     = radix_reg;
        neg_next       = neg_reg;
        bit_next       = bit_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;

        if (cmd.capture)
        begin
            q_next     = magnitude;
            rem_next   = '0;
            radix_next = radix;
            neg_next   = num_u[NW-1];
            bit_next   = '0;
            cnt_next   = '0;
        end
        if (cmd.div_step)
        begin
            q_next   = {q_reg[NW-2:0], rem_ge};
            rem_next = rem_ge ? rem_sub[DW-1:0] : rem_shift[DW-1:0];
            bit_next = bit_reg + 1'b1;
        end
        if (cmd.store_digit)
        begin
            // idx tracks the most recent digit, so it ends on the top one
            idx_next = cnt_reg[sirt_pkg::IDX_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            rem_next = '0;
            bit_next = '0;
        end
        if (cmd.idx_dec)
        begin
            idx_next = idx_reg - 1'b1;
        end

        if (cmd.load_sign || cmd.load_digit || cmd.load_empty)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg         <= '0;
            rem_reg       <= '0;
            radix_reg     <= '0;
            neg_reg       <= 1'b0;
            bit_reg       <= '0;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            q_reg         <= q_next;
            rem_reg       <= rem_next;
            radix_reg     <= radix_next;
            neg_reg       <= neg_next;
            bit_reg       <= bit_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // digit store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.store_digit)
        begin
            digit_mem[cnt_reg[sirt_pkg::IDX_W-1:0]] <= rem_reg;
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= digit_mem[idx_reg];
        end
    end

    // output payload, only loaded while the register has room
    always_ff @(posedge clk)
    begin
        if (cmd.load_empty)
        begin
            char_reg  <= sirt_pkg::NUL_CHAR;
            empty_reg <= 1'b1;
            last_reg  <= 1'b1;
        end
        else if (cmd.load_sign)
        begin
            char_reg  <= sirt_pkg::MINUS_CHAR;
            empty_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else if (cmd.load_digit)
        begin
            char_reg  <= sirt_pkg::digit_char(rd_data_reg);
            empty_reg <= 1'b0;
            last_reg  <= (idx_reg == '0);
        end
    end

    assign sts.div_last  = (bit_reg == sirt_pkg::BIT_CNT_W'(NW - 1));
    assign sts.quot_zero = (q_reg == '0);
    assign sts.negative  = neg_reg;
    assign sts.idx_zero  = (idx_reg == '0);
    assign sts.out_free  = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign is_empty  = empty_reg;
    assign last      = last_reg;

    // partial remainder stays below the base while dividing
    `SIRT_IMPLY(a_rem_range, clk, rst_n, cmd.div_step, rem_reg < DW'(radix_reg))
    // a store write never runs past the end of the digit store
    `SIRT_IMPLY(a_store_room, clk, rst_n, cmd.store_digit, cnt_reg < sirt_pkg::CNT_W'(NW))
    // a digit beat always reads an entry that was written in this conversion
    `SIRT_IMPLY(a_read_written, clk, rst_n, cmd.rd_issue, sirt_pkg::CNT_W'(idx_reg) < cnt_reg)

endmodule

// ===== rtl/signed_int_to_radix_text_top.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_radix_text_top
// converts a signed 32-bit number to its text in base 2..36, one character
// per output beat, most significant first, negatives with a leading minus sign
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid / in_stall  | number[31:0] signed, radix[5:0]
//  out     | out_valid / out_stall| character[7:0], is_empty, last
//
//  the bit-serial divider gives one quotient bit per cycle, then the
//  digit is stored; each character is read out of the digit store
//  (ST_READ, then ST_PUT) and a minus sign is loaded in ST_SIGN;
//  a new item is taken only after the last beat of the one before is
//  loaded, and out_stall holding the output register holds this up too
//  an invalid base goes to ST_EMPTY, which loads its empty beat once the
//  output register has room, and then back to idle for the next item
//  in_stall is high from accept until the last beat is loaded
//  rst_n clears the sequencer and counters; the digit store is not cleared
// ----------------------------------------------------------------------------
module signed_int_to_radix_text_top (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    in_valid,
    output logic                                    in_stall,
    input  logic signed [sirt_pkg::NUMBER_WIDTH-1:0] number,
    input  logic [sirt_pkg::RADIX_W-1:0]            radix,
    output logic                                    out_valid,
    input  logic                                    out_stall,
    output logic [sirt_pkg::CHAR_W-1:0]             character,
    output logic                                    is_empty,
    output logic                                    last
);

    sirt_pkg::cmd_t cmd;
    sirt_pkg::sts_t sts;

    sirt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .radix    (radix),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    sirt_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .number    (number),
        .radix     (radix),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .is_empty  (is_empty),
        .last      (last)
    );

endmodule
